### sv/segi_pkg.sv
package segi_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned EFF_BITS_MAX   = 29;
  localparam int unsigned EFF_BITS_MIN   = 2;

endpackage

### sv/segi_if.sv
interface segi_in_if #(
  parameter int unsigned W = segi_pkg::COORD_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] a_start_x;
  logic [W-1:0] a_start_y;
  logic [W-1:0] a_end_x;
  logic [W-1:0] a_end_y;
  logic [W-1:0] b_start_x;
  logic [W-1:0] b_start_y;
  logic [W-1:0] b_end_x;
  logic [W-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface segi_out_if #(
  parameter int unsigned W = segi_pkg::COORD_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic         hit;
  logic [W-1:0] cross_x;
  logic [W-1:0] cross_y;

  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

### sv/segi_div_step.sv
module segi_div_step #(
  parameter int unsigned E = segi_pkg::COORD_BITS_DEF
) (
  input  logic [2*E:0] r_in,
  input  logic [E-1:0] q_in,
  input  logic [2*E:0] nn,
  input  logic [2*E:0] dd,
  input  logic         b,
  output logic [2*E:0] r_out,
  output logic [E-1:0] q_out
);
  localparam int unsigned RW = 2*E + 1;
  localparam int unsigned TW = RW + 3;

  logic signed [TW-1:0] t0, c1, c2;

  // r < dd and nn <= dd, so 2r + nn < 3dd: quotient digit is 0, 1 or 2
  always_comb begin
    t0 = signed'(TW'({r_in, 1'b0})) + (b ? signed'(TW'(nn)) : '0);
    c1 = t0 - signed'(TW'(dd));
    c2 = t0 - signed'(TW'({dd, 1'b0}));
    if (!c2[TW-1]) begin
      r_out = c2[RW-1:0];
      q_out = {q_in[E-2:0], 1'b0} + E'(2);
    end else if (!c1[TW-1]) begin
      r_out = c1[RW-1:0];
      q_out = {q_in[E-2:0], 1'b1};
    end else begin
      r_out = t0[RW-1:0];
      q_out = {q_in[E-2:0], 1'b0};
    end
  end
endmodule

### sv/segment_intersection.sv
// EFF = COORD_BITS limited to 2..29. Stages from accepted item to result:
// differences, products, cross terms, range test, one long-division stage per
// coordinate bit, output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous active-low rst_n clears all stage valid bits.
module segment_intersection #(
  parameter int unsigned COORD_BITS = segi_pkg::COORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  segi_in_if.sink         in_ch,
  segi_out_if.source      out_ch
);
  import segi_pkg::*;

  localparam int unsigned E  = (COORD_BITS > EFF_BITS_MAX) ? EFF_BITS_MAX :
                               ((COORD_BITS < EFF_BITS_MIN) ? EFF_BITS_MIN : COORD_BITS);
  localparam int unsigned W1 = E + 1;
  localparam int unsigned PW = 2*E + 1;
  localparam int unsigned DW = 2*E + 2;
  localparam int unsigned OW = E + 2;

  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: differences
  logic signed [E-1:0] iax0, iay0, iax1, iay1, ibx0, iby0, ibx1, iby1;
  assign iax0 = in_ch.a_start_x[E-1:0];
  assign iay0 = in_ch.a_start_y[E-1:0];
  assign iax1 = in_ch.a_end_x[E-1:0];
  assign iay1 = in_ch.a_end_y[E-1:0];
  assign ibx0 = in_ch.b_start_x[E-1:0];
  assign iby0 = in_ch.b_start_y[E-1:0];
  assign ibx1 = in_ch.b_end_x[E-1:0];
  assign iby1 = in_ch.b_end_y[E-1:0];

  logic                v1_r;
  logic signed [W1-1:0] s1x_r, s1y_r, s2x_r, s2y_r, dx_r, dy_r;
  logic signed [E-1:0]  ax1_r, ay1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
    if (adv) begin
      s1x_r <= W1'(iax1) - W1'(iax0);
      s1y_r <= W1'(iay1) - W1'(iay0);
      s2x_r <= W1'(ibx1) - W1'(ibx0);
      s2y_r <= W1'(iby1) - W1'(iby0);
      dx_r  <= W1'(iax0) - W1'(ibx0);
      dy_r  <= W1'(iay0) - W1'(iby0);
      ax1_r <= iax0;
      ay1_r <= iay0;
    end
  end

  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [W1-1:0] s1x2_r, s1y2_r;
  logic signed [E-1:0]  ax2_r, ay2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      p1_r   <= PW'(s1x_r) * PW'(s2y_r);
      p2_r   <= PW'(s2x_r) * PW'(s1y_r);
      p3_r   <= PW'(s1x_r) * PW'(dy_r);
      p4_r   <= PW'(s1y_r) * PW'(dx_r);
      p5_r   <= PW'(s2x_r) * PW'(dy_r);
      p6_r   <= PW'(s2y_r) * PW'(dx_r);
      s1x2_r <= s1x_r;
      s1y2_r <= s1y_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
    end
  end

  // stage 3: cross terms
  logic                 v3_r;
  logic signed [DW-1:0] den_r, sn_r, tn_r;
  logic signed [W1-1:0] s1x3_r, s1y3_r;
  logic signed [E-1:0]  ax3_r, ay3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      den_r  <= DW'(p1_r) - DW'(p2_r);
      sn_r   <= DW'(p3_r) - DW'(p4_r);
      tn_r   <= DW'(p5_r) - DW'(p6_r);
      s1x3_r <= s1x2_r;
      s1y3_r <= s1y2_r;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
    end
  end

  // range test and magnitudes feeding division level 0
  logic          den_pos, sn_ok, tn_ok, hit_c;
  logic [DW-1:0] den_abs, tn_abs;
  logic [W1-1:0] sx_abs, sy_abs;

  always_comb begin
    den_pos = !den_r[DW-1];
    if (den_pos) begin
      sn_ok = !sn_r[DW-1] && (sn_r <= den_r);
      tn_ok = !tn_r[DW-1] && (tn_r <= den_r);
    end else begin
      sn_ok = (sn_r <= 0) && (sn_r >= den_r);
      tn_ok = (tn_r <= 0) && (tn_r >= den_r);
    end
    hit_c   = (den_r != '0) && sn_ok && tn_ok;
    den_abs = den_r[DW-1] ? DW'(-den_r) : DW'(den_r);
    tn_abs  = tn_r[DW-1] ? DW'(-tn_r) : DW'(tn_r);
    sx_abs  = s1x3_r[W1-1] ? W1'(-s1x3_r) : W1'(s1x3_r);
    sy_abs  = s1y3_r[W1-1] ? W1'(-s1y3_r) : W1'(s1y3_r);
  end

  // division levels 0..E
  logic                dv_r   [E+1];
  logic                hit_r  [E+1];
  logic [PW-1:0]       nn_r   [E+1];
  logic [PW-1:0]       dd_r   [E+1];
  logic [E-1:0]        ssx_r  [E+1];
  logic [E-1:0]        ssy_r  [E+1];
  logic                negx_r [E+1];
  logic                negy_r [E+1];
  logic signed [E-1:0] axd_r  [E+1];
  logic signed [E-1:0] ayd_r  [E+1];
  logic [PW-1:0]       rx_r   [E+1];
  logic [PW-1:0]       ry_r   [E+1];
  logic [E-1:0]        qx_r   [E+1];
  logic [E-1:0]        qy_r   [E+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= v3_r;
    end
    if (adv) begin
      hit_r[0]  <= hit_c;
      nn_r[0]   <= tn_abs[PW-1:0];
      dd_r[0]   <= den_abs[PW-1:0];
      ssx_r[0]  <= sx_abs[E-1:0];
      ssy_r[0]  <= sy_abs[E-1:0];
      negx_r[0] <= s1x3_r[W1-1];
      negy_r[0] <= s1y3_r[W1-1];
      axd_r[0]  <= ax3_r;
      ayd_r[0]  <= ay3_r;
      rx_r[0]   <= '0;
      ry_r[0]   <= '0;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= E; k++) begin : g_div
    logic [PW-1:0] rx_c, ry_c;
    logic [E-1:0]  qx_c, qy_c;

    segi_div_step #(.E(E)) u_x (
      .r_in  (rx_r[k-1]),
      .q_in  (qx_r[k-1]),
      .nn    (nn_r[k-1]),
      .dd    (dd_r[k-1]),
      .b     (ssx_r[k-1][E-k]),
      .r_out (rx_c),
      .q_out (qx_c)
    );
    segi_div_step #(.E(E)) u_y (
      .r_in  (ry_r[k-1]),
      .q_in  (qy_r[k-1]),
      .nn    (nn_r[k-1]),
      .dd    (dd_r[k-1]),
      .b     (ssy_r[k-1][E-k]),
      .r_out (ry_c),
      .q_out (qy_c)
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (adv) begin
        dv_r[k] <= dv_r[k-1];
      end
      if (adv) begin
        hit_r[k]  <= hit_r[k-1];
        nn_r[k]   <= nn_r[k-1];
        dd_r[k]   <= dd_r[k-1];
        ssx_r[k]  <= ssx_r[k-1];
        ssy_r[k]  <= ssy_r[k-1];
        negx_r[k] <= negx_r[k-1];
        negy_r[k] <= negy_r[k-1];
        axd_r[k]  <= axd_r[k-1];
        ayd_r[k]  <= ayd_r[k-1];
        rx_r[k]   <= rx_c;
        ry_r[k]   <= ry_c;
        qx_r[k]   <= qx_c;
        qy_r[k]   <= qy_c;
      end
    end
  end

  // floor for negative direction, add start, clamp; zero on a miss
  localparam logic signed [OW-1:0] HI = OW'((2**(E-1)) - 1);
  localparam logic signed [OW-1:0] LO = -HI - OW'(1);

  logic signed [OW-1:0] offx, offy, sumx, sumy;
  logic [E-1:0]         cx_nxt, cy_nxt;

  always_comb begin
    offx = negx_r[E] ? (-signed'(OW'(qx_r[E])) - OW'(rx_r[E] != '0))
                     : signed'(OW'(qx_r[E]));
    offy = negy_r[E] ? (-signed'(OW'(qy_r[E])) - OW'(ry_r[E] != '0))
                     : signed'(OW'(qy_r[E]));
    sumx = OW'(axd_r[E]) + offx;
    sumy = OW'(ayd_r[E]) + offy;
    if (!hit_r[E])      cx_nxt = '0;
    else if (sumx > HI) cx_nxt = HI[E-1:0];
    else if (sumx < LO) cx_nxt = LO[E-1:0];
    else                cx_nxt = sumx[E-1:0];
    if (!hit_r[E])      cy_nxt = '0;
    else if (sumy > HI) cy_nxt = HI[E-1:0];
    else if (sumy < LO) cy_nxt = LO[E-1:0];
    else                cy_nxt = sumy[E-1:0];
  end

  logic         ov_r, hit_o_r;
  logic [E-1:0] cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv_r[E];
    end
    if (adv) begin
      hit_o_r <= hit_r[E];
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
    end
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.hit     = hit_o_r;
  assign out_ch.cross_x = COORD_BITS'(cx_r);
  assign out_ch.cross_y = COORD_BITS'(cy_r);

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !hit_o_r |-> cx_r == '0 && cy_r == '0)
    else $error("miss result with nonzero point");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted item not in first stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(dv_r[E]) && $stable(v3_r) && $stable(ov_r))
    else $error("pipeline moved during stall");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    adv && dv_r[E] |=> ov_r)
    else $error("last division stage item lost");
`endif
endmodule
